/* rtl/fstc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the filesystem type classifier.
package fstc_pkg;

  // Root directory entries are 32 bytes: multiply by shifting
  localparam int unsigned ROOT_SHIFT = 5;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  // (entries << 5) + (bytes - 1) stays below 2^22
  localparam int unsigned ROOT_NUM_W = 16 + ROOT_SHIFT + 1;
  localparam int unsigned PROD_W     = 40;   // 8-bit copies x 32-bit FAT size
  localparam int unsigned OVH_W      = 41;   // reserved + FAT area + root area
  localparam int unsigned TOTAL_W    = 32;

  typedef enum logic [2:0] {
    VOL_FAT12 = 3'd0,
    VOL_FAT16 = 3'd1,
    VOL_FAT32 = 3'd2,
    VOL_EXT2  = 3'd3,
    VOL_EXT3  = 3'd4,
    VOL_EXT4  = 3'd5
  } vol_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAT12_LIMIT  = 3'd0,
    REG_FAT16_LIMIT  = 3'd1,
    REG_EXTENT_MASK  = 3'd2,
    REG_JOURNAL_MASK = 3'd3,
    REG_EXT_MAGIC    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] magic_word;
    logic [31:0] incompat_features;
    logic [31:0] compat_features;
    logic [15:0] fat_sectors_small;
    logic [31:0] fat_sectors_large;
    logic [15:0] root_entry_count;
    logic [15:0] sector_bytes;
    logic [15:0] total_sectors_small;
    logic [31:0] total_sectors_large;
    logic [15:0] reserved_sector_count;
    logic [7:0]  fat_copies;
    logic [7:0]  cluster_sectors;
  } fstc_item_t;

  typedef struct packed {
    logic [2:0]  volume_type;
    logic [31:0] cluster_total;
    logic        divide_error;
  } fstc_result_t;

  // Context that rides along the root-sector divider
  typedef struct packed {
    logic              is_ext;
    vol_type_t         ext_type;
    logic              div_err;
    logic [PROD_W-1:0] fat_area;
    logic [15:0]       reserved;
    logic [TOTAL_W-1:0] total;
    logic [7:0]        per_cluster;
  } fstc_root_side_t;

  // Context that rides along the cluster divider
  typedef struct packed {
    logic      is_ext;
    vol_type_t ext_type;
    logic      div_err;
  } fstc_clus_side_t;

endpackage

/* rtl/fstc_div_cell.sv */
`timescale 1ns / 1ps
// One restoring-division cell: resolves one quotient bit and registers it.
module fstc_div_cell
  import fstc_pkg::*;
#(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  logic [NW-1:0] up_num,
  input  logic [DW-1:0] up_rem,
  input  logic [DW-1:0] up_div,
  input  logic [SW-1:0] up_side,
  output logic          valid,
  output logic [NW-1:0] num,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] div,
  output logic [SW-1:0] side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] num_next;

  // Bring down the next dividend bit, subtract when the divisor fits
  always_comb begin
    trial    = {up_rem, up_num[NW-1]};
    diff     = trial - {1'b0, up_div};
    fits     = (trial >= {1'b0, up_div});
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    num_next = {up_num[NW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    num  <= num_next;
    rem  <= rem_next;
    div  <= up_div;
    side <= up_side;
  end

endmodule

/* rtl/fstc_div_chain.sv */
`timescale 1ns / 1ps
// Row of division cells: NW registered cells give an NW-bit quotient.
module fstc_div_chain
  import fstc_pkg::*;
#(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] up_side,
  output logic          valid,
  output logic [NW-1:0] quotient,
  output logic [SW-1:0] side
);

  logic          v_c [NW+1];
  logic [NW-1:0] n_c [NW+1];
  logic [DW-1:0] r_c [NW+1];
  logic [DW-1:0] d_c [NW+1];
  logic [SW-1:0] s_c [NW+1];

  assign v_c[0] = up_valid;
  assign n_c[0] = dividend;
  assign r_c[0] = '0;
  assign d_c[0] = divisor;
  assign s_c[0] = up_side;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    fstc_div_cell #(
      .NW(NW),
      .DW(DW),
      .SW(SW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(v_c[k]),
      .up_num  (n_c[k]),
      .up_rem  (r_c[k]),
      .up_div  (d_c[k]),
      .up_side (s_c[k]),
      .valid   (v_c[k+1]),
      .num     (n_c[k+1]),
      .rem     (r_c[k+1]),
      .div     (d_c[k+1]),
      .side    (s_c[k+1])
    );
  end

  // Final remainder and divisor are not needed downstream
  assign valid    = v_c[NW];
  assign quotient = n_c[NW];
  assign side     = s_c[NW];

endmodule

/* rtl/filesystem_type_classifier.sv */
`timescale 1ns / 1ps
// Top level of the filesystem type classifier: ext check and FAT cluster count.
// Item path: stage A, the root divider row, stages B and C, the cluster divider row, then the output register.
// Throughput: one item per cycle; the two divider cell rows (22 and 32 cells) are
// fully pipelined, so busy only rises while rst is held.
// Reset: clears all valid flags in flight and restores the five registers to defaults.
// The receiver cannot stall: done is a one-cycle strobe and result is valid with it.
module filesystem_type_classifier
  import fstc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fstc_item_t           item,
  output logic                 done,
  output fstc_result_t         result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] fat12_limit;
  logic [31:0] fat16_limit;
  logic [31:0] extent_mask;
  logic [31:0] journal_mask;
  logic [15:0] ext_magic;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat12_limit  <= 32'd4084;
      fat16_limit  <= 32'd65524;
      extent_mask  <= 32'd64;
      journal_mask <= 32'd4;
      ext_magic    <= 16'd61267;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAT12_LIMIT:  fat12_limit  <= cfg_data;
        REG_FAT16_LIMIT:  fat16_limit  <= cfg_data;
        REG_EXTENT_MASK:  extent_mask  <= cfg_data;
        REG_JOURNAL_MASK: journal_mask <= cfg_data;
        REG_EXT_MAGIC:    ext_magic    <= cfg_data[15:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Every stage advances every cycle; hold off new items only during reset
  assign busy = rst;

  // ---------------------------------------------------------------------------
  // Stage A: decode the item, select 16/32-bit fields, form FAT area and the
  // root directory sector numerator (entries * 32 + bytes - 1)
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic [31:0]           fat_secs_a;
  logic [TOTAL_W-1:0]    total_a;
  fstc_root_side_t       side_a;
  logic [ROOT_NUM_W-1:0] root_num_a;

  assign accept = start && !busy;

  always_comb begin
    fat_secs_a = (item.fat_sectors_small != '0) ? {16'b0, item.fat_sectors_small}
                                                : item.fat_sectors_large;
    total_a    = (item.total_sectors_small != '0) ? {16'b0, item.total_sectors_small}
                                                  : item.total_sectors_large;

    side_a.is_ext = (item.magic_word == ext_magic);
    // Extent bits win over journal bits
    if ((item.incompat_features & extent_mask) != '0) begin
      side_a.ext_type = VOL_EXT4;
    end else if ((item.compat_features & journal_mask) != '0) begin
      side_a.ext_type = VOL_EXT3;
    end else begin
      side_a.ext_type = VOL_EXT2;
    end
    side_a.div_err     = (item.sector_bytes == '0) || (item.cluster_sectors == '0);
    side_a.fat_area    = PROD_W'(item.fat_copies) * PROD_W'(fat_secs_a);
    side_a.reserved    = item.reserved_sector_count;
    side_a.total       = total_a;
    side_a.per_cluster = item.cluster_sectors;

    // With a zero sector size this can wrap; the error flag overrides the result
    root_num_a = {1'b0, item.root_entry_count, {ROOT_SHIFT{1'b0}}}
               + ROOT_NUM_W'(item.sector_bytes) - ROOT_NUM_W'(1);
  end

  logic                  a_valid;
  fstc_root_side_t       a_side;
  logic [ROOT_NUM_W-1:0] a_root_num;
  logic [15:0]           a_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_side     <= side_a;
    a_root_num <= root_num_a;
    a_bytes    <= item.sector_bytes;
  end

  // ---------------------------------------------------------------------------
  // Root directory sectors: one cell per quotient bit
  // ---------------------------------------------------------------------------
  logic                  r_valid;
  logic [ROOT_NUM_W-1:0] root_sectors;
  fstc_root_side_t       r_side;

  fstc_div_chain #(
    .NW(ROOT_NUM_W),
    .DW(16),
    .SW($bits(fstc_root_side_t))
  ) u_root_div (
    .clk     (clk),
    .rst     (rst),
    .up_valid(a_valid),
    .dividend(a_root_num),
    .divisor (a_bytes),
    .up_side (a_side),
    .valid   (r_valid),
    .quotient(root_sectors),
    .side    (r_side)
  );

  // ---------------------------------------------------------------------------
  // Stage B: sum the overhead sectors (reserved + FAT area + root area)
  // ---------------------------------------------------------------------------
  logic               b_valid;
  logic [OVH_W-1:0]   b_overhead;
  logic [TOTAL_W-1:0] b_total;
  logic [7:0]         b_per_cluster;
  fstc_clus_side_t    b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_overhead      <= OVH_W'(r_side.reserved) + OVH_W'(r_side.fat_area)
                     + OVH_W'(root_sectors);
    b_total         <= r_side.total;
    b_per_cluster   <= r_side.per_cluster;
    b_side.is_ext   <= r_side.is_ext;
    b_side.ext_type <= r_side.ext_type;
    b_side.div_err  <= r_side.div_err;
  end

  // ---------------------------------------------------------------------------
  // Stage C: data sectors, clamped to zero when overhead reaches the total.
  // When total exceeds overhead, overhead fits in 32 bits, so a 32-bit
  // subtract is exact.
  // ---------------------------------------------------------------------------
  logic               c_valid;
  logic [TOTAL_W-1:0] c_data;
  logic [7:0]         c_per_cluster;
  fstc_clus_side_t    c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_data        <= (OVH_W'(b_total) > b_overhead) ? (b_total - b_overhead[TOTAL_W-1:0])
                                                    : '0;
    c_per_cluster <= b_per_cluster;
    c_side        <= b_side;
  end

  // ---------------------------------------------------------------------------
  // Cluster count: data sectors / sectors per cluster
  // ---------------------------------------------------------------------------
  logic               q_valid;
  logic [TOTAL_W-1:0] clusters;
  fstc_clus_side_t    q_side;

  fstc_div_chain #(
    .NW(TOTAL_W),
    .DW(8),
    .SW($bits(fstc_clus_side_t))
  ) u_clus_div (
    .clk     (clk),
    .rst     (rst),
    .up_valid(c_valid),
    .dividend(c_data),
    .divisor (c_per_cluster),
    .up_side (c_side),
    .valid   (q_valid),
    .quotient(clusters),
    .side    (q_side)
  );

  // ---------------------------------------------------------------------------
  // Output stage: threshold the count and pick the ext / error override
  // ---------------------------------------------------------------------------
  fstc_result_t result_next;

  always_comb begin
    if (q_side.is_ext) begin
      result_next.volume_type   = q_side.ext_type;
      result_next.cluster_total = '0;
      result_next.divide_error  = 1'b0;
    end else if (q_side.div_err) begin
      result_next.volume_type   = VOL_FAT12;
      result_next.cluster_total = '0;
      result_next.divide_error  = 1'b1;
    end else begin
      if (clusters <= fat12_limit) begin
        result_next.volume_type = VOL_FAT12;
      end else if (clusters <= fat16_limit) begin
        result_next.volume_type = VOL_FAT16;
      end else begin
        result_next.volume_type = VOL_FAT32;
      end
      result_next.cluster_total = clusters;
      result_next.divide_error  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the filesystem type classifier: random and directed headers, scoreboard check.
module tb_top;
  import fstc_pkg::*;

  // Register defaults after reset
  localparam logic [31:0] FAT12_LIMIT_RST  = 32'd4084;
  localparam logic [31:0] FAT16_LIMIT_RST  = 32'd65524;
  localparam logic [31:0] EXTENT_MASK_RST  = 32'd64;
  localparam logic [31:0] JOURNAL_MASK_RST = 32'd4;
  localparam logic [15:0] EXT_MAGIC_RST    = 16'hEF53;

  // First index past the register file; writes there must be ignored
  localparam int unsigned REG_SPARE_FIRST  = 5;
  localparam int unsigned REG_SPARE_LAST   = (1 << CFG_IDX_W) - 1;

  localparam int unsigned ROOT_ENTRY_BYTES = 32;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned SETTLE_CYCLES    = 64;        // beyond the block's latency
  localparam int unsigned IDLE_LIGHT       = 10;        // percent of cycles the sender idles
  localparam int unsigned IDLE_HEAVY       = 71;
  localparam int unsigned IDLE_NONE        = 0;
  localparam realtime     RUN_LIMIT        = 2_000_000; // ns, far above the slowest run

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  fstc_item_t    item;
  logic          done;
  fstc_result_t  result;
  logic          cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  filesystem_type_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scoreboard: keeps its own copy of the five registers, predicts the
  // verdict of every accepted header and matches verdicts in order.
  class volume_type_board;
    logic [31:0]  fat12_limit;
    logic [31:0]  fat16_limit;
    logic [31:0]  extent_mask;
    logic [31:0]  journal_mask;
    logic [15:0]  ext_magic;
    fstc_result_t expected_verdicts[$];
    int unsigned  mismatches;

    function new();
      fat12_limit  = FAT12_LIMIT_RST;
      fat16_limit  = FAT16_LIMIT_RST;
      extent_mask  = EXTENT_MASK_RST;
      journal_mask = JOURNAL_MASK_RST;
      ext_magic    = EXT_MAGIC_RST;
      mismatches   = 0;
    endfunction

    // Mirror a register write; unknown indexes fall through untouched
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FAT12_LIMIT:  fat12_limit  = val;
        REG_FAT16_LIMIT:  fat16_limit  = val;
        REG_EXTENT_MASK:  extent_mask  = val;
        REG_JOURNAL_MASK: journal_mask = val;
        REG_EXT_MAGIC:    ext_magic    = val[15:0];
        default: ;
      endcase
    endfunction

    // Expected verdict for one header, all FAT arithmetic in 64 bits
    function fstc_result_t classify_volume(fstc_item_t hdr);
      fstc_result_t verdict;
      logic [63:0]  fat_len;
      logic [63:0]  root_sec;
      logic [63:0]  total;
      logic [63:0]  overhead;
      logic [63:0]  data_sec;
      logic [63:0]  clusters;
      verdict = '0;
      if (hdr.magic_word == ext_magic) begin
        // ext: extents win over journal, cluster count stays zero
        if ((hdr.incompat_features & extent_mask) != '0) begin
          verdict.volume_type = VOL_EXT4;
        end else if ((hdr.compat_features & journal_mask) != '0) begin
          verdict.volume_type = VOL_EXT3;
        end else begin
          verdict.volume_type = VOL_EXT2;
        end
      end else if (hdr.sector_bytes == '0 || hdr.cluster_sectors == '0) begin
        verdict.volume_type  = VOL_FAT12;
        verdict.divide_error = 1'b1;
      end else begin
        fat_len  = (hdr.fat_sectors_small == '0) ? 64'(hdr.fat_sectors_large)
                                                 : 64'(hdr.fat_sectors_small);
        root_sec = (64'(hdr.root_entry_count) * ROOT_ENTRY_BYTES
                    + 64'(hdr.sector_bytes) - 64'd1) / 64'(hdr.sector_bytes);
        total    = (hdr.total_sectors_small == '0) ? 64'(hdr.total_sectors_large)
                                                   : 64'(hdr.total_sectors_small);
        overhead = 64'(hdr.reserved_sector_count) + 64'(hdr.fat_copies) * fat_len
                   + root_sec;
        // clamp to zero when the overhead swallows the volume
        data_sec = (total > overhead) ? total - overhead : 64'd0;
        clusters = data_sec / 64'(hdr.cluster_sectors);
        if (clusters <= 64'(fat12_limit)) begin
          verdict.volume_type = VOL_FAT12;
        end else if (clusters <= 64'(fat16_limit)) begin
          verdict.volume_type = VOL_FAT16;
        end else begin
          verdict.volume_type = VOL_FAT32;
        end
        verdict.cluster_total = clusters[31:0];
      end
      return verdict;
    endfunction

    function void note_header(fstc_item_t hdr);
      expected_verdicts.push_back(classify_volume(hdr));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s", msg);
      end
    endfunction

    function void check_verdict(fstc_result_t got);
      fstc_result_t want;
      if (expected_verdicts.size() == 0) begin
        flag($sformatf("unexpected result: type %0d clusters %0d error %0b",
                       got.volume_type, got.cluster_total, got.divide_error));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.volume_type !== want.volume_type) begin
        flag($sformatf("volume_type mismatch: expected %0d got %0d",
                       want.volume_type, got.volume_type));
      end
      if (got.cluster_total !== want.cluster_total) begin
        flag($sformatf("cluster_total mismatch: expected %0d got %0d",
                       want.cluster_total, got.cluster_total));
      end
      if (got.divide_error !== want.divide_error) begin
        flag($sformatf("divide_error mismatch: expected %0b got %0b",
                       want.divide_error, got.divide_error));
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  volume_type_board board;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results
  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Sample both sides at the rising edge: a header is taken when start is
  // high and busy low, a verdict whenever done strobes.
  always @(posedge clk) begin
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0) begin
        board.note_header(item);
      end
      if (done === 1'b1) begin
        board.check_verdict(result);
      end
    end
  end

  // All driving tasks start and end just after a falling edge.

  // Present one header and hold it until the block takes it
  task automatic send_header(input fstc_item_t hdr);
    item  = hdr;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Drop start for a random run of cycles, each cycle idling with pct percent
  task automatic idle_sender(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  // Hold off until every predicted verdict has come back
  task automatic drain_verdicts();
    start = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    board.set_reg(idx, val);
  endtask

  function automatic fstc_item_t fat_header(
    input logic [15:0] fat_small, input logic [31:0] fat_large,
    input logic [15:0] root,      input logic [15:0] bytes,
    input logic [15:0] tot_small, input logic [31:0] tot_large,
    input logic [15:0] rsv,       input logic [7:0]  copies,
    input logic [7:0]  per_cluster);
    fstc_item_t hdr;
    hdr = '0;
    hdr.fat_sectors_small     = fat_small;
    hdr.fat_sectors_large     = fat_large;
    hdr.root_entry_count      = root;
    hdr.sector_bytes          = bytes;
    hdr.total_sectors_small   = tot_small;
    hdr.total_sectors_large   = tot_large;
    hdr.reserved_sector_count = rsv;
    hdr.fat_copies            = copies;
    hdr.cluster_sectors       = per_cluster;
    return hdr;
  endfunction

  function automatic fstc_item_t ext_header(input logic [15:0] magic,
                                            input logic [31:0] incompat,
                                            input logic [31:0] compat);
    fstc_item_t hdr;
    hdr = '0;
    hdr.magic_word        = magic;
    hdr.incompat_features = incompat;
    hdr.compat_features   = compat;
    return hdr;
  endfunction

  // Random header: a fifth pure noise, a quarter ext superblocks, the rest
  // plausible FAT boot sectors whose totals aim at the class boundaries.
  function automatic fstc_item_t random_header();
    fstc_item_t  hdr;
    int unsigned pick;
    int unsigned aim;
    logic [63:0] fat_len;
    logic [63:0] root_sec;
    logic [63:0] overhead;
    logic [63:0] target;
    logic [63:0] total;
    hdr.magic_word            = 16'($urandom);
    hdr.incompat_features     = $urandom;
    hdr.compat_features       = $urandom;
    hdr.fat_sectors_small     = 16'($urandom);
    hdr.fat_sectors_large     = $urandom;
    hdr.root_entry_count      = 16'($urandom);
    hdr.sector_bytes          = 16'($urandom);
    hdr.total_sectors_small   = 16'($urandom);
    hdr.total_sectors_large   = $urandom;
    hdr.reserved_sector_count = 16'($urandom);
    hdr.fat_copies            = 8'($urandom);
    hdr.cluster_sectors       = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      // noise, now and then with a zero divisor
      case ($urandom_range(7))
        0: hdr.sector_bytes    = '0;
        1: hdr.cluster_sectors = '0;
        default: ;
      endcase
    end else if (pick < 45) begin
      hdr.magic_word = board.ext_magic;
      hdr.incompat_features = ($urandom_range(2) == 0) ? 32'd0 : ($urandom & $urandom & $urandom);
      hdr.compat_features   = ($urandom_range(2) == 0) ? 32'd0 : ($urandom & $urandom & $urandom);
    end else begin
      // keep clear of the ext magic, often by a single bit
      if ($urandom_range(1) == 0) begin
        hdr.magic_word = board.ext_magic ^ (16'd1 << $urandom_range(15));
      end else if (hdr.magic_word == board.ext_magic) begin
        hdr.magic_word = hdr.magic_word ^ 16'd1;
      end
      hdr.sector_bytes = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 65535))
                                                  : 16'(32'd128 << $urandom_range(5));
      hdr.cluster_sectors = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'(32'd1 << $urandom_range(7));
      if ($urandom_range(9) != 0) begin
        hdr.reserved_sector_count = 16'($urandom_range(1, 64));
        hdr.fat_copies            = 8'($urandom_range(1, 2));
      end
      case ($urandom_range(2))
        0: hdr.root_entry_count = '0;
        1: hdr.root_entry_count = 16'($urandom_range(1, 1024));
        default: ;
      endcase
      if ($urandom_range(1) == 0) begin
        hdr.fat_sectors_small = '0;
        hdr.fat_sectors_large = $urandom_range(1, 1 << 20);
      end else begin
        hdr.fat_sectors_small = 16'($urandom_range(1, 65535));
      end
      fat_len  = (hdr.fat_sectors_small == '0) ? 64'(hdr.fat_sectors_large)
                                               : 64'(hdr.fat_sectors_small);
      root_sec = (64'(hdr.root_entry_count) * ROOT_ENTRY_BYTES
                  + 64'(hdr.sector_bytes) - 64'd1) / 64'(hdr.sector_bytes);
      overhead = 64'(hdr.reserved_sector_count) + 64'(hdr.fat_copies) * fat_len + root_sec;
      aim = $urandom_range(7);
      case (aim)
        0: target = 64'(board.fat12_limit);
        1: target = 64'(board.fat12_limit) + 64'd1;
        2: target = 64'(board.fat16_limit);
        3: target = 64'(board.fat16_limit) + 64'd1;
        4: target = 64'($urandom_range(0, 100000));
        5: target = 64'($urandom);
        default: target = 64'd0;
      endcase
      if (aim >= 6) begin
        // at or below the overhead: data sectors clamp to zero
        total = overhead >> $urandom_range(3);
      end else begin
        total = overhead + target * 64'(hdr.cluster_sectors)
                + 64'($urandom_range(0, 32'(hdr.cluster_sectors) - 1));
      end
      if (total > 64'hFFFF_FFFF) begin
        total = 64'hFFFF_FFFF;
      end
      if (total <= 64'hFFFF && $urandom_range(1) == 0) begin
        hdr.total_sectors_small = total[15:0];
      end else begin
        hdr.total_sectors_small = '0;
        hdr.total_sectors_large = total[31:0];
      end
    end
    return hdr;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned pct);
    repeat (count) begin
      idle_sender(pct);
      send_header(random_header());
    end
  endtask

  task automatic send_directed();
    fstc_item_t hdr;
    // ext flavors: extents, journal only, neither, both set
    send_header(ext_header(board.ext_magic, 32'h0000_0040, 32'h0));
    send_header(ext_header(board.ext_magic, 32'h0, 32'h0000_0004));
    send_header(ext_header(board.ext_magic, 32'hFFFF_FFBF, 32'hFFFF_FFFB));
    send_header(ext_header(board.ext_magic, 32'h0000_0040, 32'h0000_0004));
    // every field at its top with the ext magic, then without it
    hdr = '1;
    hdr.magic_word = board.ext_magic;
    send_header(hdr);
    send_header('1);
    // zero divisors
    send_header('0);
    send_header(fat_header(16'd9, 32'd0, 16'd224, 16'd0, 16'd2880, 32'd0, 16'd1, 8'd2, 8'd1));
    send_header(fat_header(16'd9, 32'd0, 16'd224, 16'd512, 16'd2880, 32'd0, 16'd1, 8'd2, 8'd0));
    // floppy image, once with a magic one bit off the ext value
    hdr = fat_header(16'd9, 32'd0, 16'd224, 16'd512, 16'd2880, 32'd0, 16'd1, 8'd2, 8'd1);
    send_header(hdr);
    hdr.magic_word = board.ext_magic ^ 16'd1;
    send_header(hdr);
    // typical FAT16 and FAT32 volumes
    send_header(fat_header(16'd256, 32'd0, 16'd512, 16'd512, 16'd0, 32'd1_000_000,
                           16'd4, 8'd2, 8'd32));
    send_header(fat_header(16'd0, 32'd15_000, 16'd0, 16'd512, 16'd0, 32'd2_000_000,
                           16'd32, 8'd2, 8'd8));
    // cluster counts on either side of both class limits
    send_header(fat_header(16'd0, 32'd0, 16'd0, 16'd512, 16'd4084, 32'd0, 16'd0, 8'd0, 8'd1));
    send_header(fat_header(16'd0, 32'd0, 16'd0, 16'd512, 16'd4085, 32'd0, 16'd0, 8'd0, 8'd1));
    send_header(fat_header(16'd0, 32'd0, 16'd0, 16'd512, 16'd65524, 32'd0, 16'd0, 8'd0, 8'd1));
    send_header(fat_header(16'd0, 32'd0, 16'd0, 16'd512, 16'd65525, 32'd0, 16'd0, 8'd0, 8'd1));
    // nonzero 16-bit fields must win over the 32-bit ones
    send_header(fat_header(16'd1, 32'hFFFF_FFFF, 16'd0, 16'd512, 16'd100, 32'hFFFF_FFFF,
                           16'd0, 8'd1, 8'd1));
    // largest cluster count, largest root area, FAT area far past the total
    send_header(fat_header(16'd0, 32'd0, 16'd0, 16'd1, 16'd0, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd1));
    send_header(fat_header(16'd0, 32'd0, 16'hFFFF, 16'd1, 16'd0, 32'hFFFF_FFFF,
                           16'd0, 8'd0, 8'd1));
    send_header(fat_header(16'd0, 32'hFFFF_FFFF, 16'd0, 16'd512, 16'd0, 32'hFFFF_FFFF,
                           16'd0, 8'hFF, 8'd1));
    // overhead exactly equal to the total
    send_header(fat_header(16'd0, 32'd0, 16'd0, 16'd512, 16'd100, 32'd0, 16'd100, 8'd0, 8'd1));
  endtask

  initial begin
    board     = new();
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_FAT12_LIMIT;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Defaults: directed corners back to back, then light sender idling
    send_directed();
    run_random(130, IDLE_LIGHT);

    // Everything FAT16 above zero, any incompat feature bit means ext4, zero magic
    drain_verdicts();
    write_reg(REG_FAT12_LIMIT, 32'h0);
    write_reg(REG_FAT16_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_EXTENT_MASK, 32'hFFFF_FFFF);
    write_reg(REG_JOURNAL_MASK, 32'h0);
    write_reg(REG_EXT_MAGIC, 32'h0);
    run_random(40, IDLE_LIGHT);

    // The opposite extremes, with heavy sender idling from here
    drain_verdicts();
    write_reg(REG_FAT12_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_FAT16_LIMIT, 32'h0);
    write_reg(REG_EXTENT_MASK, 32'h0);
    write_reg(REG_JOURNAL_MASK, 32'hFFFF_FFFF);
    write_reg(REG_EXT_MAGIC, 32'h0000_FFFF);
    run_random(80, IDLE_HEAVY);

    // Random settings; writes past the register file must change nothing
    drain_verdicts();
    write_reg(REG_FAT12_LIMIT, $urandom_range(0, 100_000));
    write_reg(REG_FAT16_LIMIT, $urandom);
    write_reg(REG_EXTENT_MASK, $urandom);
    write_reg(REG_JOURNAL_MASK, $urandom);
    write_reg(REG_EXT_MAGIC, $urandom);
    for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
      write_reg(CFG_IDX_W'(idx), $urandom);
    end
    run_random(80, IDLE_HEAVY);

    // Back to the standard values, sender never idles
    drain_verdicts();
    write_reg(REG_FAT12_LIMIT, FAT12_LIMIT_RST);
    write_reg(REG_FAT16_LIMIT, FAT16_LIMIT_RST);
    write_reg(REG_EXTENT_MASK, EXTENT_MASK_RST);
    write_reg(REG_JOURNAL_MASK, JOURNAL_MASK_RST);
    write_reg(REG_EXT_MAGIC, 32'(EXT_MAGIC_RST));
    run_random(150, IDLE_NONE);

    // Let the pipeline empty, then watch for stray strobes
    drain_verdicts();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.pending() != 0) begin
      board.flag($sformatf("%0d results never arrived", board.pending()));
    end
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filesystem_type_classifier.f */
rtl/fstc_pkg.sv
rtl/fstc_div_cell.sv
rtl/fstc_div_chain.sv
rtl/filesystem_type_classifier.sv
sim/tb_top.sv
